[rtl/ehea_pkg.sv]
// Shared widths and transaction types of the event hit energy adder.
`default_nettype none

package ehea_pkg;

   localparam int unsigned E_W    = 24;          // hit energy
   localparam int unsigned P_W    = 20;          // position coordinate
   localparam int unsigned S_W    = 30;          // energy sum
   localparam int unsigned W_W    = 50;          // weighted position sum
   localparam int unsigned PROD_W = E_W + P_W + 1;

   typedef struct packed {
      logic [E_W-1:0]        hit_energy;
      logic signed [P_W-1:0] hit_x;
      logic signed [P_W-1:0] hit_y;
      logic signed [P_W-1:0] hit_z;
      logic                  last_of_event;
   } req_type;

   typedef struct packed {
      logic [S_W-1:0]        sum_energy;
      logic signed [P_W-1:0] out_x;
      logic signed [P_W-1:0] out_y;
      logic signed [P_W-1:0] out_z;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/ehea_mac.sv]
// Shared multiply and saturating accumulate unit for weighted position sums.
`default_nettype none

module ehea_mac
   import ehea_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  issue,
   input  wire logic [E_W-1:0]        energy,
   input  wire logic signed [P_W-1:0] coord,
   input  wire logic signed [W_W-1:0] acc,
   output logic signed [W_W-1:0]      sum
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [W_W:0]      prod_ext;
   logic signed [W_W:0]      total;

   // The product is registered; the add uses it in the following cycle.
   assign prod_in = $signed({1'b0, energy}) * coord;

   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_ext = {{(W_W + 1 - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign total    = {acc[W_W-1], acc} + prod_ext;

   // Clamp to the signed range of the accumulator.
   always_comb begin
      if (total[W_W:W_W-1] == 2'b01) begin
         sum = {1'b0, {(W_W-1){1'b1}}};
      end else if (total[W_W:W_W-1] == 2'b10) begin
         sum = {1'b1, {(W_W-1){1'b0}}};
      end else begin
         sum = total[W_W-1:0];
      end
   end

endmodule

`default_nettype wire

[rtl/ehea_div.sv]
// Radix-2 restoring divider that forms a clamped centroid coordinate.
`default_nettype none

module ehea_div
   import ehea_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic signed [W_W-1:0] dividend,
   input  wire logic [S_W-1:0]        divisor,
   output logic                       done,
   output logic signed [P_W-1:0]      quotient
);

   localparam int unsigned CNT_W = $clog2(W_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W_W - 1);
   localparam logic [W_W-1:0] POS_LIMIT = W_W'((64'd1 << (P_W - 1)) - 64'd1);
   localparam logic [W_W-1:0] NEG_LIMIT = W_W'(64'd1 << (P_W - 1));

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [S_W-1:0]   rem_ff, rem_in;
   logic [W_W-1:0]   quo_ff, quo_in;
   logic [S_W-1:0]   den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [S_W:0]     rem_sh;
   logic [S_W+1:0]   diff;
   logic             ge;

   assign rem_sh = {rem_ff, quo_ff[W_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};
   assign ge     = ~diff[S_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = dividend[W_W-1];
         quo_in  = dividend[W_W-1] ? W_W'(-dividend) : W_W'(dividend);
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[S_W-1:0] : rem_sh[S_W-1:0];
         quo_in = {quo_ff[W_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;

   // Truncated quotient magnitude, signed and clamped to the coordinate range.
   always_comb begin
      if (!neg_ff && (quo_ff > POS_LIMIT)) begin
         quotient = {1'b0, {(P_W-1){1'b1}}};
      end else if (neg_ff && (quo_ff > NEG_LIMIT)) begin
         quotient = {1'b1, {(P_W-1){1'b0}}};
      end else if (neg_ff) begin
         quotient = P_W'(-quo_ff);
      end else begin
         quotient = quo_ff[P_W-1:0];
      end
   end

endmodule

`default_nettype wire

[rtl/event_hit_energy_adder.sv]
// Top level of the event hit energy adder: sequencer, event state and output register.
//
// The block takes the hits of one detector event, one transaction per hit, on the
// req_ channel (req_valid, req_stall, req_data). Zero-energy hits leave the sums unchanged.
// Each other hit adds to a saturating energy sum, adds its energy-weighted position
// to three saturating sums and may become the energy winner. On the hit flagged
// last_of_event the block sends one rsp_ transaction with the summed energy and
// either the winner position or the centroid, unless the energy sum is zero.
// The one-bit policy register is written over the csr_ channel, which is always
// ready; it selects winner (0) or centroid (1) and should only change while idle.
// A nonzero hit passes through one shared multiplier that serves x, y and z in turn
// (multiply, then accumulate); a zero-energy hit skips it.
// At the end of an event the winner policy stages the result directly, while the
// centroid policy runs one radix-2 divider over the three axes in turn.
// Results wait in an output register, so the next hit is accepted while a result
// is still stalled; a second result waits until that register has been taken.
// Synchronous reset clears the policy, the event sums and any pending result.
`default_nettype none

module event_hit_energy_adder
   import ehea_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_ADD  = 3'd2;
   localparam logic [2:0] ST_END  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Y = 2'd1;
   localparam logic [1:0] AX_Z = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       policy_ff, policy_in;

   logic [S_W-1:0]        energy_accum_ff, energy_accum_in;
   logic signed [W_W-1:0] wx_ff, wx_in;
   logic signed [W_W-1:0] wy_ff, wy_in;
   logic signed [W_W-1:0] wz_ff, wz_in;
   logic [E_W-1:0]        best_energy_ff, best_energy_in;
   logic signed [P_W-1:0] best_x_ff, best_x_in;
   logic signed [P_W-1:0] best_y_ff, best_y_in;
   logic signed [P_W-1:0] best_z_ff, best_z_in;

   req_type hit_ff, hit_in;
   rsp_type stage_ff, stage_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic [S_W:0]          energy_sum;
   logic                  mac_issue;
   logic signed [P_W-1:0] mac_coord;
   logic signed [W_W-1:0] mac_acc;
   logic signed [W_W-1:0] mac_sum;
   logic [1:0]            rd_sel;
   logic                  div_start;
   logic                  div_done;
   logic signed [P_W-1:0] div_quotient;
   logic                  out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign energy_sum = {1'b0, energy_accum_ff} + {{(S_W + 1 - E_W){1'b0}}, req_data.hit_energy};

   // One read port over the three weighted sums: the accumulate step uses the
   // current axis, a divider start uses the axis that is about to be divided.
   always_comb begin
      if (state_ff == ST_ADD) begin
         rd_sel = idx_ff;
      end else if (state_ff == ST_END) begin
         rd_sel = AX_X;
      end else begin
         rd_sel = idx_ff + 2'd1;
      end
   end

   always_comb begin
      case (rd_sel)
         AX_X:    mac_acc = wx_ff;
         AX_Y:    mac_acc = wy_ff;
         default: mac_acc = wz_ff;
      endcase
      case (idx_ff)
         AX_X:    mac_coord = hit_ff.hit_x;
         AX_Y:    mac_coord = hit_ff.hit_y;
         default: mac_coord = hit_ff.hit_z;
      endcase
   end

   assign mac_issue = (state_ff == ST_MUL);

   ehea_mac u_mac (
      .clock  (clock),
      .issue  (mac_issue),
      .energy (hit_ff.hit_energy),
      .coord  (mac_coord),
      .acc    (mac_acc),
      .sum    (mac_sum)
   );

   ehea_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mac_acc),
      .divisor  (energy_accum_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      policy_in       = policy_ff;
      energy_accum_in = energy_accum_ff;
      wx_in           = wx_ff;
      wy_in           = wy_ff;
      wz_in           = wz_ff;
      best_energy_in  = best_energy_ff;
      best_x_in       = best_x_ff;
      best_y_in       = best_y_ff;
      best_z_in       = best_z_ff;
      hit_in          = hit_ff;
      stage_in        = stage_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      div_start       = 1'b0;

      if (csr_valid) begin
         policy_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hit_in = req_data;
               idx_in = AX_X;
               if (req_data.hit_energy != '0) begin
                  // Energy sum and winner update happen at acceptance.
                  energy_accum_in = energy_sum[S_W] ? {S_W{1'b1}} : energy_sum[S_W-1:0];
                  if (req_data.hit_energy > best_energy_ff) begin
                     best_energy_in = req_data.hit_energy;
                     best_x_in      = req_data.hit_x;
                     best_y_in      = req_data.hit_y;
                     best_z_in      = req_data.hit_z;
                  end
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_END;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            case (idx_ff)
               AX_X:    wx_in = mac_sum;
               AX_Y:    wy_in = mac_sum;
               default: wz_in = mac_sum;
            endcase
            if (idx_ff == AX_Z) begin
               state_in = ST_END;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_END: begin
            if (!hit_ff.last_of_event) begin
               state_in = ST_IDLE;
            end else if (energy_accum_ff == '0) begin
               // Empty event: nothing to report, the state is already clear.
               state_in = ST_IDLE;
            end else begin
               stage_in.sum_energy = energy_accum_ff;
               if (!policy_ff) begin
                  stage_in.out_x  = best_x_ff;
                  stage_in.out_y  = best_y_ff;
                  stage_in.out_z  = best_z_ff;
                  energy_accum_in = '0;
                  wx_in           = '0;
                  wy_in           = '0;
                  wz_in           = '0;
                  best_energy_in  = '0;
                  best_x_in       = '0;
                  best_y_in       = '0;
                  best_z_in       = '0;
                  state_in        = ST_OUT;
               end else begin
                  idx_in    = AX_X;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               case (idx_ff)
                  AX_X:    stage_in.out_x = div_quotient;
                  AX_Y:    stage_in.out_y = div_quotient;
                  default: stage_in.out_z = div_quotient;
               endcase
               if (idx_ff == AX_Z) begin
                  energy_accum_in = '0;
                  wx_in           = '0;
                  wy_in           = '0;
                  wz_in           = '0;
                  best_energy_in  = '0;
                  best_x_in       = '0;
                  best_y_in       = '0;
                  best_z_in       = '0;
                  state_in        = ST_OUT;
               end else begin
                  idx_in    = idx_ff + 2'd1;
                  div_start = 1'b1;
               end
            end
         end
         ST_OUT: begin
            // Hand the staged result to the output register once it is free.
            if (out_free) begin
               rsp_data_in  = stage_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         idx_ff          <= AX_X;
         policy_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         energy_accum_ff <= '0;
         wx_ff           <= '0;
         wy_ff           <= '0;
         wz_ff           <= '0;
         best_energy_ff  <= '0;
         best_x_ff       <= '0;
         best_y_ff       <= '0;
         best_z_ff       <= '0;
      end else begin
         state_ff        <= state_in;
         idx_ff          <= idx_in;
         policy_ff       <= policy_in;
         rsp_valid_ff    <= rsp_valid_in;
         energy_accum_ff <= energy_accum_in;
         wx_ff           <= wx_in;
         wy_ff           <= wy_in;
         wz_ff           <= wz_in;
         best_energy_ff  <= best_energy_in;
         best_x_ff       <= best_x_in;
         best_y_ff       <= best_y_in;
         best_z_ff       <= best_z_in;
      end
      hit_ff      <= hit_in;
      stage_ff    <= stage_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide phase");

   // A result is only staged for an event with a nonzero energy sum.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (stage_ff.sum_energy != '0))
      else $error("staged result carries a zero energy sum");

   // Any nonzero energy sum implies a winner with nonzero energy.
   assert property (@(posedge clock) disable iff (reset)
      (energy_accum_ff != '0) |-> (best_energy_ff != '0))
      else $error("energy sum without an energy winner");

   // After the last hit the event state is cleared unless the divider runs.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_END) && hit_ff.last_of_event)
         |=> ((state_ff == ST_DIV) || (energy_accum_ff == '0)))
      else $error("event state not cleared at end of event");

   // A pending result is never overwritten while the receiver stalls.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result changed");

endmodule

`default_nettype wire
